>>> sv/cpnm_pkg.sv
// Shared types, constants and helpers for the class pattern matcher.
`timescale 1ns / 1ps

package cpnm_pkg;

    // Pattern capacity and derived widths
    localparam int MAX_TOKENS = 256;
    localparam int TOT_W      = $clog2(MAX_TOKENS + 1);
    localparam int HELD_W     = 9;
    localparam int OUT_W      = 16;

    // Command codes carried on tuser
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_PATTERN = 2'd1,
        CMD_START   = 2'd2,
        CMD_STRING  = 2'd3
    } cmd_t;

    // Token kinds
    typedef enum logic [1:0] {
        KIND_LIT   = 2'd0,
        KIND_DIGIT = 2'd1,
        KIND_ALPHA = 2'd2,
        KIND_OTHER = 2'd3
    } kind_t;

    // Character codes
    localparam logic [7:0] CH_UPPER_A   = 8'h41;
    localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LOWER_A   = 8'h61;
    localparam logic [7:0] CH_LOWER_Z   = 8'h7A;
    localparam logic [7:0] CH_LOWER_D   = 8'h64;
    localparam logic [7:0] CH_LOWER_P   = 8'h70;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;

    // Broadcast from the control logic to every cell
    typedef struct packed {
        logic              push;      // write a token at index total
        kind_t             kind;
        logic [7:0]        lit;
        logic [TOT_W-1:0]  total;     // tokens currently held
        logic              step;      // advance on a string byte
        logic              restart;   // back to position zero only
        logic [7:0]        chr;       // folded string byte
        logic              is_digit;
        logic              is_lower;
    } cpnm_bcast_t;

    // Status out of each cell
    typedef struct packed {
        logic pass;      // next position becomes active
        logic active;
        logic end_hit;   // active and sitting at the end of the pattern
    } cpnm_stat_t;

    // Fold A-Z to lower case
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        fold_case = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

endpackage

>>> sv/cpnm_cell.sv
// One token cell: holds a token and the active bit of its position.
`timescale 1ns / 1ps

module cpnm_cell
    import cpnm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [TOT_W-1:0]  cell_idx,
    input  cpnm_bcast_t       bc,
    input  logic              pass_in,
    output cpnm_stat_t        stat
);

    kind_t      kind_reg;
    logic [7:0] lit_reg;
    logic       act_reg;
    logic       act_next;
    logic       in_pat;
    logic       hit;
    logic       is_first;

    assign is_first = (cell_idx == '0);
    assign in_pat   = (cell_idx < bc.total);

    // Token store, written once per pattern at its own index
    always_ff @(posedge clk)
    begin
        if (bc.push && (bc.total == cell_idx))
        begin
            kind_reg <= bc.kind;
            lit_reg  <= bc.lit;
        end
    end

    // Does the current byte satisfy this token
    always_comb
    begin
        unique case (kind_reg)
            KIND_LIT:   hit = (bc.chr == lit_reg);
            KIND_DIGIT: hit = bc.is_digit;
            KIND_ALPHA: hit = bc.is_lower;
            KIND_OTHER: hit = !(bc.is_digit || bc.is_lower);
            default:    hit = 1'b0;
        endcase
    end

    // Active bit update: classes may stay, any hit passes on
    always_comb
    begin
        priority if (bc.restart)
            act_next = is_first;
        else if (bc.step)
            act_next = (act_reg && in_pat && hit && (kind_reg != KIND_LIT)) || pass_in;
        else
            act_next = act_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            act_reg <= is_first;
        else
            act_reg <= act_next;
    end

    assign stat.pass    = act_reg && in_pat && hit;
    assign stat.active  = act_reg;
    assign stat.end_hit = act_reg && (cell_idx == bc.total);

endmodule

>>> sv/class_pattern_nfa_matcher_core.sv
// Top level: pattern lexer, row of token cells and output staging.
// Results: state registers hold each result until the output register is free.
// Throughput: one item per cycle unless m_axis stalls; all cells update at once.
// The output register plus one pending result let one item in while a result waits.
// Reset: empty pattern, no error, only position zero active; no clearing pass.
`timescale 1ns / 1ps

module class_pattern_nfa_matcher_core
    import cpnm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]       s_axis_tuser,   // [1:0] cmd
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata    // [0] matched, [1] alive, [2] pattern_bad,
                                             // [11:3] tokens_held, rest zero
);

    localparam logic [TOT_W-1:0] FULL_COUNT = TOT_W'(MAX_TOKENS);

    logic [TOT_W-1:0] total_reg, total_next;
    logic             esc_reg, esc_next;
    logic             err_reg, err_next;
    logic             end_act_reg, end_act_next;
    logic             pend_reg;
    logic             out_valid_reg;
    logic [OUT_W-1:0] out_data_reg;

    logic             in_acc;
    logic             move;
    logic             full;
    cmd_t             cmd;
    logic [7:0]       chr;
    logic [7:0]       esc_chr;
    cpnm_bcast_t      bc;
    cpnm_stat_t       stat [MAX_TOKENS];
    logic [MAX_TOKENS-1:0] act_vec;
    logic [MAX_TOKENS-1:0] end_vec;
    logic             matched;
    logic             alive;
    logic [OUT_W-1:0] result;

    assign cmd     = cmd_t'(s_axis_tuser);
    assign chr     = fold_case(s_axis_tdata);
    assign esc_chr = chr;
    assign full    = (total_reg == FULL_COUNT);

    // Handshake: state holds one undelivered result, output register another
    assign move          = pend_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !pend_reg || move;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // Lexer and command decode
    always_comb
    begin
        total_next  = total_reg;
        esc_next    = esc_reg;
        err_next    = err_reg;
        bc.push     = 1'b0;
        bc.kind     = KIND_LIT;
        bc.lit      = chr;
        bc.step     = 1'b0;
        bc.restart  = 1'b0;
        bc.total    = total_reg;
        bc.chr      = chr;
        bc.is_digit = (chr >= CH_ZERO) && (chr <= CH_NINE);
        bc.is_lower = (chr >= CH_LOWER_A) && (chr <= CH_LOWER_Z);
        if (in_acc)
        begin
            unique case (cmd)
                CMD_CLEAR:
                begin
                    total_next = '0;
                    esc_next   = 1'b0;
                    err_next   = 1'b0;
                    bc.restart = 1'b1;
                end
                CMD_PATTERN:
                begin
                    if (!err_reg)
                    begin
                        if (esc_reg)
                        begin
                            esc_next = 1'b0;
                            priority if (esc_chr == CH_LOWER_D)
                                bc.kind = KIND_DIGIT;
                            else if (esc_chr == CH_LOWER_A)
                                bc.kind = KIND_ALPHA;
                            else if (esc_chr == CH_LOWER_P)
                                bc.kind = KIND_OTHER;
                            else
                                bc.kind = KIND_LIT;
                            if (esc_chr == CH_LOWER_D || esc_chr == CH_LOWER_A ||
                                esc_chr == CH_LOWER_P || esc_chr == CH_BACKSLASH)
                            begin
                                if (full)
                                    err_next = 1'b1;
                                else
                                begin
                                    bc.push    = 1'b1;
                                    total_next = total_reg + 1'b1;
                                end
                            end
                            else
                                err_next = 1'b1;
                        end
                        else if (s_axis_tdata == CH_BACKSLASH)
                        begin
                            if (full)
                                err_next = 1'b1;
                            else
                                esc_next = 1'b1;
                        end
                        else if (full)
                            err_next = 1'b1;
                        else
                        begin
                            bc.push    = 1'b1;
                            total_next = total_reg + 1'b1;
                        end
                    end
                end
                CMD_START:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        err_next = 1'b1;
                    end
                    bc.restart = 1'b1;
                end
                CMD_STRING:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                        err_next = 1'b1;
                    end
                    bc.step = 1'b1;
                end
                default:
                begin
                    bc.step = 1'b0;
                end
            endcase
        end
    end

    // Row of token cells, each passing its hit to the next position
    for (genvar i = 0; i < MAX_TOKENS; i++)
    begin : g_cell
        logic pass_in;
        if (i == 0)
        begin : g_first
            assign pass_in = 1'b0;
        end
        else
        begin : g_rest
            assign pass_in = stat[i-1].pass;
        end

        cpnm_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (TOT_W'(i)),
            .bc       (bc),
            .pass_in  (pass_in),
            .stat     (stat[i])
        );

        assign act_vec[i] = stat[i].active;
        assign end_vec[i] = stat[i].end_hit;
    end

    // Final position past the last token
    always_comb
    begin
        priority if (bc.restart)
            end_act_next = 1'b0;
        else if (bc.step)
            end_act_next = stat[MAX_TOKENS-1].pass;
        else
            end_act_next = end_act_reg;
    end

    // Result from the state left by the last accepted item
    assign matched = ((|end_vec) || (end_act_reg && full)) && !err_reg;
    assign alive   = (|act_vec) || end_act_reg;
    assign result  = OUT_W'({HELD_W'(total_reg), err_reg, alive, matched});

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            esc_reg       <= 1'b0;
            err_reg       <= 1'b0;
            end_act_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg   <= total_next;
            esc_reg     <= esc_next;
            err_reg     <= err_next;
            end_act_reg <= end_act_next;
            pend_reg    <= in_acc || (pend_reg && !move);
            if (move)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (move)
            out_data_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> verif/tb_class_pattern_nfa_matcher_core.sv
// Self-checking stream testbench for the class pattern matcher core.
`timescale 1ns / 1ps

module tb_class_pattern_nfa_matcher_core;
    import cpnm_pkg::*;

    // One input item: command on tuser, byte on tdata
    typedef struct {
        cmd_t       cmd;
        logic [7:0] data;
    } feed_item_t;

    // Result word, laid out as on m_axis_tdata (matched in bit 0)
    typedef struct packed {
        logic [3:0] pad;
        logic [8:0] held;
        logic       bad;
        logic       alive;
        logic       matched;
    } match_res_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    logic             s_axis_tready;
    logic [7:0]       s_axis_tdata = 8'd0;   // [7:0] data_byte
    logic [1:0]       s_axis_tuser = 2'd0;   // [1:0] cmd
    logic             m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;          // [0] matched, [1] alive, [2] pattern_bad,
                                             // [11:3] tokens_held, rest zero

    class_pattern_nfa_matcher_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock, 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Queues and handshake bookkeeping
    feed_item_t feed_q[$];
    match_res_t expect_q[$];
    int         raised_cnt = 0;
    int         acc_cnt = 0;
    int         res_cnt = 0;
    int         res_seen = 0;
    int         feed_gap = 0;
    int         sink_stall = 0;
    bit         feed_calm = 1'b0;
    bit         sink_calm = 1'b0;
    int         faults = 0;

    // Matcher state mirrored by the predictor
    kind_t             tok_kind [MAX_TOKENS];
    logic [7:0]        tok_lit [MAX_TOKENS];
    int                tok_count = 0;
    bit                esc_wait = 1'b0;
    bit                bad = 1'b0;
    logic [MAX_TOKENS:0] live = (MAX_TOKENS + 1)'(1);

    // Tokens of the pattern last generated, used to build matching strings
    kind_t      pat_kind[$];
    logic [7:0] pat_lit[$];

    function automatic logic [7:0] fold_byte(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            return c + CASE_OFFSET;
        return c;
    endfunction

    function automatic bit is_word(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LOWER_A && c <= CH_LOWER_Z);
    endfunction

    function automatic bit class_takes(input kind_t k, input logic [7:0] c);
        case (k)
            KIND_DIGIT: return c >= CH_ZERO && c <= CH_NINE;
            KIND_ALPHA: return c >= CH_LOWER_A && c <= CH_LOWER_Z;
            default:    return !is_word(c);
        endcase
    endfunction

    task automatic add_token(input kind_t k, input logic [7:0] lit);
        if (tok_count >= MAX_TOKENS)
            bad = 1'b1;
        else
        begin
            tok_kind[tok_count] = k;
            tok_lit[tok_count] = lit;
            tok_count++;
        end
    endtask

    // Advance the mirrored matcher by one item and give the result it reports
    task automatic step_matcher(input cmd_t cmd, input logic [7:0] b, output match_res_t r);
        logic [7:0]          c;
        logic [MAX_TOKENS:0] nxt;
        case (cmd)
            CMD_CLEAR:
            begin
                tok_count = 0;
                esc_wait = 1'b0;
                bad = 1'b0;
                live = (MAX_TOKENS + 1)'(1);
            end
            CMD_PATTERN:
            begin
                // a pattern with an error stays frozen
                if (!bad)
                begin
                    if (esc_wait)
                    begin
                        c = fold_byte(b);
                        esc_wait = 1'b0;
                        if (c == CH_LOWER_D)
                            add_token(KIND_DIGIT, 8'd0);
                        else if (c == CH_LOWER_A)
                            add_token(KIND_ALPHA, 8'd0);
                        else if (c == CH_LOWER_P)
                            add_token(KIND_OTHER, 8'd0);
                        else if (c == CH_BACKSLASH)
                            add_token(KIND_LIT, CH_BACKSLASH);
                        else
                            bad = 1'b1;
                    end
                    else if (b == CH_BACKSLASH)
                    begin
                        if (tok_count >= MAX_TOKENS)
                            bad = 1'b1;
                        else
                            esc_wait = 1'b1;
                    end
                    else
                        add_token(KIND_LIT, fold_byte(b));
                end
            end
            default:
            begin
                // trailing backslash closes with an error
                if (esc_wait)
                begin
                    esc_wait = 1'b0;
                    bad = 1'b1;
                end
                if (cmd == CMD_START)
                    live = (MAX_TOKENS + 1)'(1);
                else
                begin
                    c = fold_byte(b);
                    nxt = '0;
                    for (int i = 0; i < tok_count; i++)
                    begin
                        if (live[i])
                        begin
                            if (tok_kind[i] == KIND_LIT)
                            begin
                                if (c == tok_lit[i])
                                    nxt[i+1] = 1'b1;
                            end
                            else if (class_takes(tok_kind[i], c))
                            begin
                                nxt[i] = 1'b1;
                                nxt[i+1] = 1'b1;
                            end
                        end
                    end
                    live = nxt;
                end
            end
        endcase
        r.pad = 4'd0;
        r.held = tok_count[8:0];
        r.bad = bad;
        r.alive = |live;
        r.matched = live[tok_count] && !bad;
    endtask

    task automatic note_fault(input string msg);
        faults++;
        if (faults <= 10)
            $display("%s", msg);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
            note_fault($sformatf("result %0d: %s expected %0d, got %0d",
                                 res_cnt, name, want, got));
    endtask

    // Input driver: one item at a time from feed_q, random gap after each
    always @(negedge clk)
    begin : feed_drive
        logic       hold;
        feed_item_t it;
        hold = s_axis_tvalid;
        if (rst_n)
        begin
            if (hold && acc_cnt == raised_cnt)
                hold = 1'b0;
            if (!hold)
            begin
                if (feed_gap > 0)
                    feed_gap--;
                else if (feed_q.size() > 0)
                begin
                    it = feed_q.pop_front();
                    s_axis_tdata <= it.data;
                    s_axis_tuser <= it.cmd;
                    hold = 1'b1;
                    raised_cnt++;
                    if ($urandom_range(0, 39) == 0)
                        feed_calm = !feed_calm;
                    feed_gap = feed_calm ? 0 : $urandom_range(0, 11);
                end
            end
        end
        s_axis_tvalid <= hold;
    end

    // Result receiver: random stall after each result
    always @(negedge clk)
    begin : sink
        if (rst_n)
        begin
            if (res_cnt != res_seen)
            begin
                res_seen = res_cnt;
                if ($urandom_range(0, 39) == 0)
                    sink_calm = !sink_calm;
                sink_stall = sink_calm ? 0 : $urandom_range(0, 11);
            end
            if (sink_stall > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_stall--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Monitor: check results, then predict for the item taken at this edge
    always @(posedge clk)
    begin : watch
        match_res_t got;
        match_res_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                res_cnt++;
                got = match_res_t'(m_axis_tdata);
                if (expect_q.size() == 0)
                    note_fault($sformatf("result %0d (%h) arrived with nothing expected",
                                         res_cnt, m_axis_tdata));
                else
                begin
                    want = expect_q.pop_front();
                    check_field("matched", int'(want.matched), int'(got.matched));
                    check_field("alive", int'(want.alive), int'(got.alive));
                    check_field("pattern_bad", int'(want.bad), int'(got.bad));
                    check_field("tokens_held", int'(want.held), int'(got.held));
                    check_field("padding", int'(want.pad), int'(got.pad));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                acc_cnt++;
                step_matcher(cmd_t'(s_axis_tuser), s_axis_tdata, want);
                expect_q.push_back(want);
            end
        end
    end

    task automatic queue_item(input cmd_t c, input logic [7:0] d);
        feed_item_t it;
        it.cmd = c;
        it.data = d;
        feed_q.push_back(it);
    endtask

    // Random byte that a class token accepts
    function automatic logic [7:0] class_byte(input kind_t k);
        logic [7:0] b;
        case (k)
            KIND_DIGIT: b = 8'($urandom_range(CH_ZERO, CH_NINE));
            KIND_ALPHA:
            begin
                b = 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
                if ($urandom_range(0, 1))
                    b = b - CASE_OFFSET;
            end
            default:
            begin
                b = 8'($urandom_range(0, 255));
                while (is_word(fold_byte(b)))
                    b = 8'($urandom_range(0, 255));
            end
        endcase
        return b;
    endfunction

    // Emit n well-formed tokens as pattern bytes and remember them
    task automatic make_tokens(input int n);
        int         r;
        kind_t      k;
        logic [7:0] b;
        pat_kind.delete();
        pat_lit.delete();
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_BACKSLASH)
                    b = CH_UPPER_Z;
                queue_item(CMD_PATTERN, b);
                pat_kind.push_back(KIND_LIT);
                pat_lit.push_back(fold_byte(b));
            end
            else if (r < 62)
            begin
                queue_item(CMD_PATTERN, CH_BACKSLASH);
                queue_item(CMD_PATTERN, CH_BACKSLASH);
                pat_kind.push_back(KIND_LIT);
                pat_lit.push_back(CH_BACKSLASH);
            end
            else
            begin
                k = kind_t'($urandom_range(1, 3));
                b = (k == KIND_DIGIT) ? CH_LOWER_D : (k == KIND_ALPHA) ? CH_LOWER_A : CH_LOWER_P;
                if ($urandom_range(0, 1))
                    b = b - CASE_OFFSET;
                queue_item(CMD_PATTERN, CH_BACKSLASH);
                queue_item(CMD_PATTERN, b);
                pat_kind.push_back(k);
                pat_lit.push_back(8'd0);
            end
        end
    endtask

    // Start a string that matches the remembered tokens, optionally spoilt
    task automatic make_string(input bit spoil);
        logic [7:0] s[$];
        logic [7:0] b;
        foreach (pat_kind[i])
        begin
            if (pat_kind[i] == KIND_LIT)
            begin
                b = pat_lit[i];
                if (b >= CH_LOWER_A && b <= CH_LOWER_Z && $urandom_range(0, 1))
                    b = b - CASE_OFFSET;
                s.push_back(b);
            end
            else
                repeat ($urandom_range(1, 3))
                    s.push_back(class_byte(pat_kind[i]));
        end
        if (spoil)
        begin
            case ($urandom_range(0, 2))
                0:
                begin
                    if (s.size() > 0)
                        s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
                end
                1:
                begin
                    if (s.size() > 0)
                        void'(s.pop_back());
                end
                default: s.push_back(8'($urandom_range(0, 255)));
            endcase
        end
        queue_item(CMD_START, 8'($urandom_range(0, 255)));
        foreach (s[i])
            queue_item(CMD_STRING, s[i]);
    endtask

    // Mixed traffic, mostly well-formed pattern and string sequences
    task automatic random_traffic(input int budget);
        int         first;
        int         r;
        int         n;
        logic [7:0] b;
        first = feed_q.size() + raised_cnt;
        while (feed_q.size() + raised_cnt - first < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 65)
            begin
                queue_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
                n = $urandom_range(0, 99);
                n = (n < 5) ? 0 : (n < 90) ? $urandom_range(1, 6) : $urandom_range(7, 24);
                make_tokens(n);
                repeat ($urandom_range(1, 3))
                begin
                    make_string($urandom_range(0, 99) < 25);
                    // pattern grows while the string is running
                    if ($urandom_range(0, 9) == 0)
                    begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_BACKSLASH)
                            b = CH_ZERO;
                        queue_item(CMD_PATTERN, b);
                        queue_item(CMD_STRING, b);
                        pat_kind.push_back(KIND_LIT);
                        pat_lit.push_back(fold_byte(b));
                    end
                end
            end
            else if (r < 78)
            begin
                // broken pattern: unknown escape or trailing backslash
                queue_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
                make_tokens($urandom_range(0, 4));
                queue_item(CMD_PATTERN, CH_BACKSLASH);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        b = 8'($urandom_range(0, 255));
                        while (fold_byte(b) == CH_LOWER_D || fold_byte(b) == CH_LOWER_A ||
                               fold_byte(b) == CH_LOWER_P || b == CH_BACKSLASH)
                            b = 8'($urandom_range(0, 255));
                        queue_item(CMD_PATTERN, b);
                    end
                    1: ;
                    default: queue_item(CMD_STRING, 8'($urandom_range(0, 255)));
                endcase
                queue_item(CMD_PATTERN, 8'($urandom_range(0, 255)));
                make_string(1'b0);
            end
            else if (r < 92)
            begin
                repeat ($urandom_range(1, 8))
                    queue_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
            else
            begin
                // string bytes with no start command
                repeat ($urandom_range(1, 6))
                    queue_item(CMD_STRING, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Hold the sender back until every expected result is in
    task automatic wait_drained();
        while (feed_q.size() != 0 || s_axis_tvalid || acc_cnt != raised_cnt ||
               expect_q.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [7:0] b;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // empty pattern: start matches at once, a string byte kills it
        queue_item(CMD_START, 8'hFF);
        queue_item(CMD_STRING, 8'h00);
        queue_item(CMD_CLEAR, 8'hA5);
        // pattern: A \D \\ \a \P 0xFF
        queue_item(CMD_PATTERN, CH_UPPER_A);
        queue_item(CMD_PATTERN, CH_BACKSLASH);
        queue_item(CMD_PATTERN, CH_LOWER_D - CASE_OFFSET);
        queue_item(CMD_PATTERN, CH_BACKSLASH);
        queue_item(CMD_PATTERN, CH_BACKSLASH);
        queue_item(CMD_PATTERN, CH_BACKSLASH);
        queue_item(CMD_PATTERN, CH_LOWER_A);
        queue_item(CMD_PATTERN, CH_BACKSLASH);
        queue_item(CMD_PATTERN, CH_LOWER_P - CASE_OFFSET);
        queue_item(CMD_PATTERN, 8'hFF);
        queue_item(CMD_START, CH_BACKSLASH);
        queue_item(CMD_STRING, CH_UPPER_A);
        queue_item(CMD_STRING, CH_NINE);
        queue_item(CMD_STRING, CH_BACKSLASH);
        queue_item(CMD_STRING, CH_UPPER_Z);
        queue_item(CMD_STRING, 8'h00);
        queue_item(CMD_STRING, 8'hFF);
        // backslash mid-string, then a string byte leaves it trailing
        queue_item(CMD_PATTERN, CH_BACKSLASH);
        queue_item(CMD_STRING, CH_ZERO);
        queue_item(CMD_PATTERN, CH_UPPER_A);
        // zero byte as escape letter
        queue_item(CMD_CLEAR, 8'h00);
        queue_item(CMD_PATTERN, CH_BACKSLASH);
        queue_item(CMD_PATTERN, 8'h00);
        // trailing backslash caught by a start command
        queue_item(CMD_CLEAR, 8'h00);
        queue_item(CMD_PATTERN, CH_BACKSLASH);
        queue_item(CMD_START, 8'h00);
        wait_drained();

        random_traffic(25);

        // full pattern, last slot a class, a string through all of it
        queue_item(CMD_CLEAR, 8'($urandom_range(0, 255)));
        pat_kind.delete();
        pat_lit.delete();
        repeat (MAX_TOKENS - 1)
        begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_BACKSLASH)
                b = CH_UPPER_Z;
            queue_item(CMD_PATTERN, b);
            pat_kind.push_back(KIND_LIT);
            pat_lit.push_back(fold_byte(b));
        end
        queue_item(CMD_PATTERN, CH_BACKSLASH);
        queue_item(CMD_PATTERN, CH_LOWER_D);
        pat_kind.push_back(KIND_DIGIT);
        pat_lit.push_back(8'd0);
        make_string(1'b0);
        // one token too many, by a literal or by a backslash
        queue_item(CMD_PATTERN, $urandom_range(0, 1) ? CH_BACKSLASH : CH_UPPER_Z);
        queue_item(CMD_STRING, 8'($urandom_range(0, 255)));
        wait_drained();

        random_traffic(25);
        wait_drained();
        repeat (16) @(negedge clk);

        if (faults == 0)
            $display("tb_class_pattern_nfa_matcher_core OK");
        else
            $display("tb_class_pattern_nfa_matcher_core NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("tb_class_pattern_nfa_matcher_core NOT OK");
        $finish;
    end

endmodule
